/* sv/stick_to_servo_and_esc_mapper_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the stick to servo and ESC mapper
// Concurrent property wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef STICK_TO_SERVO_AND_ESC_MAPPER_ASSERT_SVH
`define STICK_TO_SERVO_AND_ESC_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSEM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ssem_pkg.sv */
// ---------------------------------------------------------------------------
// Stick to servo and ESC mapper package
// Field widths, register indexes and mapping constants.
// ---------------------------------------------------------------------------
package ssem_pkg;

  // Field widths.
  localparam int STICK_W    = 16;
  localparam int READ_W     = 10;
  localparam int ANGLE_W    = 8;
  localparam int PULSE_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 1'b1;

  // Register reset values.
  localparam logic [READ_W-1:0] DEADZONE_RESET = 10'd25;
  localparam logic [READ_W-1:0] CENTER_RESET   = 10'd523;

  // Mapping constants.
  localparam logic [READ_W-1:0]  IN_LO    = 10'd350;
  localparam logic [READ_W-1:0]  IN_HI    = 10'd700;
  localparam logic [ANGLE_W-1:0] ANG_LO   = 8'd45;
  localparam logic [ANGLE_W-1:0] ANG_HI   = 8'd135;
  localparam logic [ANGLE_W-1:0] GAS_MAX  = 8'd180;
  localparam logic [ANGLE_W-1:0] GAS_MID  = 8'd90;
  localparam logic [PULSE_W-1:0] PULSE_LO = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_HI = 11'd2000;

  // 90/350 = 9/35, 180/350 = 18/35, 1000/90 = 100/9.
  localparam int ANGLE_MUL = 9;
  localparam int GAS_MUL   = 18;
  localparam int PULSE_MUL = 100;

  // Reciprocals for division by 35 and by 9, exact over the operand ranges used.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP35     = 3745;
  localparam int RECIP9      = 14564;

endpackage

/* sv/ssem_ifs.sv */
// ---------------------------------------------------------------------------
// Stick to servo and ESC mapper channels
// Valid/ready channels for the stick packet and the mapped result.
// ---------------------------------------------------------------------------
interface ssem_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ssem_pkg::STICK_W-1:0]       left_vertical;
  logic signed [ssem_pkg::STICK_W-1:0]       right_horizontal;
  logic signed [ssem_pkg::STICK_W-1:0]       right_vertical;

  modport source (output valid, left_vertical, right_horizontal, right_vertical,
                  input ready);
  modport sink   (input valid, left_vertical, right_horizontal, right_vertical,
                  output ready);
endinterface

interface ssem_out_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [ssem_pkg::ANGLE_W-1:0]    pair_angle;
  logic [ssem_pkg::ANGLE_W-1:0]    single_angle;
  logic [ssem_pkg::PULSE_W-1:0]    motor_pulse_us;
  logic                            pair_write;
  logic                            single_write;
  logic                            motor_write;

  modport source (output valid, accepted, pair_angle, single_angle, motor_pulse_us,
                         pair_write, single_write, motor_write,
                  input ready);
  modport sink   (input valid, accepted, pair_angle, single_angle, motor_pulse_us,
                        pair_write, single_write, motor_write,
                  output ready);
endinterface

/* sv/stick_to_servo_and_esc_mapper.sv */
// ---------------------------------------------------------------------------
// Stick to servo and ESC mapper
// Turns one packet of three stick readings into two servo angles and an ESC
// pulse width, with change-detect write strobes.
// ---------------------------------------------------------------------------
// Usage:
// Packets enter on the valid/ready channel "packet" and results leave on
// "result"; every packet gives exactly one result, in order. A packet with
// any reading outside 0..1023 gives a result with every field at zero and
// leaves the change-detect history alone.
// The block is a three-register pipeline: an input register, a middle
// register after the dead zone and linear maps (the constant-reciprocal
// multiplies), and the result register after the pulse map and the change
// compare. An accepted packet passes the input, middle and result registers in
// turn; one packet can be taken every clock cycle while packet.ready is high.
// When the receiver holds ready low, the result register keeps its item and
// stages behind it fill; packet.ready falls only once all three are full.
// Synchronous reset empties the pipeline, sets the dead zone to 25 and the
// centre to 523, and sets the last-written history to all ones so that the
// first accepted packet fires every write strobe.
// The configuration port writes a register whenever cfg_we is high; it
// should only be used while no packet is in flight.
// ---------------------------------------------------------------------------
module stick_to_servo_and_esc_mapper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  ssem_in_if.sink                             packet,
  ssem_out_if.source                          result
);

`include "stick_to_servo_and_esc_mapper_assert.svh"

  localparam int RW = ssem_pkg::READ_W;
  localparam int AW = ssem_pkg::ANGLE_W;
  localparam int PW = ssem_pkg::PULSE_W;
  localparam int SW = ssem_pkg::STICK_W;

  // A reading is in range when it is non-negative and fits in ten bits.
  function automatic logic in_range(logic signed [SW-1:0] s);
    return !s[SW-1] && (s[SW-2:RW] == '0);
  endfunction

  // Replace a reading closer to the centre than the dead zone by the centre.
  function automatic logic [RW-1:0] snap(logic [RW-1:0] v, logic [RW-1:0] c,
                                         logic [RW-1:0] dz);
    logic [RW:0]   d;
    logic [RW-1:0] mag;
    d   = {1'b0, v} - {1'b0, c};
    mag = d[RW] ? RW'((RW+1)'(0) - d) : d[RW-1:0];
    return (mag < dz) ? c : v;
  endfunction

  // 350..700 onto 45..135 degrees, clamped.
  function automatic logic [AW-1:0] map_angle(logic [RW-1:0] x);
    logic [RW-2:0] n;
    logic [11:0]   n9;
    logic [23:0]   prod;
    n    = (RW-1)'(x - ssem_pkg::IN_LO);
    n9   = 12'(n) * 12'(ssem_pkg::ANGLE_MUL);
    prod = 24'(n9) * 24'(ssem_pkg::RECIP35);
    if (x <= ssem_pkg::IN_LO) begin
      return ssem_pkg::ANG_LO;
    end else if (x >= ssem_pkg::IN_HI) begin
      return ssem_pkg::ANG_HI;
    end
    return ssem_pkg::ANG_LO + AW'(prod[23:ssem_pkg::RECIP_SHIFT]);
  endfunction

  // 350..700 onto a 0..180 throttle, clamped.
  function automatic logic [AW-1:0] map_gas(logic [RW-1:0] x);
    logic [RW-2:0] n;
    logic [12:0]   n18;
    logic [25:0]   prod;
    n    = (RW-1)'(x - ssem_pkg::IN_LO);
    n18  = 13'(n) * 13'(ssem_pkg::GAS_MUL);
    prod = 26'(n18) * 26'(ssem_pkg::RECIP35);
    if (x <= ssem_pkg::IN_LO) begin
      return '0;
    end else if (x >= ssem_pkg::IN_HI) begin
      return ssem_pkg::GAS_MAX;
    end
    return AW'(prod[25:ssem_pkg::RECIP_SHIFT]);
  endfunction

  // Throttle above the midpoint maps 90..180 onto 1000..2000 us.
  function automatic logic [PW-1:0] map_pulse(logic [AW-1:0] gas);
    logic [6:0]  d;
    logic [13:0] m;
    logic [27:0] prod;
    d    = 7'(gas - ssem_pkg::GAS_MID);
    m    = 14'(d) * 14'(ssem_pkg::PULSE_MUL);
    prod = 28'(m) * 28'(ssem_pkg::RECIP9);
    if (gas <= ssem_pkg::GAS_MID) begin
      return ssem_pkg::PULSE_LO;
    end
    return ssem_pkg::PULSE_LO + PW'(prod[27:ssem_pkg::RECIP_SHIFT]);
  endfunction

  // Configuration registers.
  logic [RW-1:0] deadzone_width;
  logic [RW-1:0] stick_center;

  // Change-detect history.
  logic [AW-1:0] last_pair_angle;
  logic [AW-1:0] last_single_angle;
  logic [PW-1:0] last_motor_pulse;

  // Input register.
  logic                 in_valid;
  logic signed [SW-1:0] in_lv;
  logic signed [SW-1:0] in_rh;
  logic signed [SW-1:0] in_rv;

  // Middle register.
  logic          mid_valid;
  logic          mid_acc;
  logic [AW-1:0] mid_pair;
  logic [AW-1:0] mid_single;
  logic [AW-1:0] mid_gas;

  // Result register.
  logic          out_valid;
  logic          out_acc;
  logic [AW-1:0] out_pair;
  logic [AW-1:0] out_single;
  logic [PW-1:0] out_pulse;
  logic          out_pair_wr;
  logic          out_single_wr;
  logic          out_motor_wr;

  // Pipeline flow: each stage may load when it is empty or the stage after it
  // is loading.
  logic out_load;
  logic mid_load;
  logic in_load;

  assign out_load     = !out_valid || result.ready;
  assign mid_load     = !mid_valid || out_load;
  assign in_load      = !in_valid || mid_load;
  assign packet.ready = in_load;

  // First half of the work: range check, dead zone and the linear maps.
  logic          s1_acc;
  logic [RW-1:0] s1_lv;
  logic [RW-1:0] s1_rh;
  logic [RW-1:0] s1_rv;

  always_comb begin
    s1_acc = in_range(in_lv) && in_range(in_rh) && in_range(in_rv);
    s1_lv  = snap(in_lv[RW-1:0], stick_center, deadzone_width);
    s1_rh  = snap(in_rh[RW-1:0], stick_center, deadzone_width);
    s1_rv  = snap(in_rv[RW-1:0], stick_center, deadzone_width);
  end

  // Second half: pulse map and comparison with the last values written.
  // A rejected packet gives an all-zero result.
  logic [PW-1:0] s2_pulse;
  logic          s2_pair_wr;
  logic          s2_single_wr;
  logic          s2_motor_wr;

  always_comb begin
    s2_pulse     = map_pulse(mid_gas);
    s2_pair_wr   = mid_acc && (mid_pair != last_pair_angle);
    s2_single_wr = mid_acc && (mid_single != last_single_angle);
    s2_motor_wr  = mid_acc && (s2_pulse != last_motor_pulse);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_width <= ssem_pkg::DEADZONE_RESET;
      stick_center   <= ssem_pkg::CENTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssem_pkg::REG_DEADZONE: deadzone_width <= cfg_wdata[RW-1:0];
        ssem_pkg::REG_CENTER:   stick_center   <= cfg_wdata[RW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      mid_valid         <= 1'b0;
      out_valid         <= 1'b0;
      last_pair_angle   <= '1;
      last_single_angle <= '1;
      last_motor_pulse  <= '1;
    end else begin
      if (in_load) begin
        in_valid <= packet.valid;
      end
      if (mid_load) begin
        mid_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= mid_valid;
      end
      // The history only moves when an accepted item enters the result register.
      if (out_load && mid_valid && mid_acc) begin
        last_pair_angle   <= mid_pair;
        last_single_angle <= mid_single;
        last_motor_pulse  <= s2_pulse;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && packet.valid) begin
      in_lv <= packet.left_vertical;
      in_rh <= packet.right_horizontal;
      in_rv <= packet.right_vertical;
    end
    if (mid_load && in_valid) begin
      mid_acc    <= s1_acc;
      mid_pair   <= s1_acc ? map_angle(s1_lv) : '0;
      mid_single <= s1_acc ? map_angle(s1_rh) : '0;
      mid_gas    <= map_gas(s1_rv);
    end
    if (out_load && mid_valid) begin
      out_acc       <= mid_acc;
      out_pair      <= mid_pair;
      out_single    <= mid_single;
      out_pulse     <= mid_acc ? s2_pulse : '0;
      out_pair_wr   <= s2_pair_wr;
      out_single_wr <= s2_single_wr;
      out_motor_wr  <= s2_motor_wr;
    end
  end

  assign result.valid          = out_valid;
  assign result.accepted       = out_acc;
  assign result.pair_angle     = out_pair;
  assign result.single_angle   = out_single;
  assign result.motor_pulse_us = out_pulse;
  assign result.pair_write     = out_pair_wr;
  assign result.single_write   = out_single_wr;
  assign result.motor_write    = out_motor_wr;

  // A rejected packet never asks for a servo or ESC write.
  `SSEM_ASSERT_SAME(a_reject_no_write, result.valid && !result.accepted, !result.pair_write && !result.single_write && !result.motor_write, "write strobe on a rejected packet")

  // Accepted results lie inside the clamped spans.
  `SSEM_ASSERT_SAME(a_span, result.valid && result.accepted, (result.pair_angle >= ssem_pkg::ANG_LO) && (result.pair_angle <= ssem_pkg::ANG_HI) && (result.single_angle >= ssem_pkg::ANG_LO) && (result.single_angle <= ssem_pkg::ANG_HI) && (result.motor_pulse_us >= ssem_pkg::PULSE_LO) && (result.motor_pulse_us <= ssem_pkg::PULSE_HI), "accepted result outside its span")

  // The history follows the accepted item just loaded into the result register.
  `SSEM_ASSERT_NEXT(a_history, out_load && mid_valid && mid_acc, (last_pair_angle == result.pair_angle) && (last_single_angle == result.single_angle) && (last_motor_pulse == result.motor_pulse_us), "history out of step with result")

  // An empty result register never stalls the input.
  `SSEM_ASSERT_SAME(a_empty_ready, !result.valid, packet.ready, "input stalled with empty result register")

endmodule
